FILE: hw/rtl/sle_pkg.sv
`default_nettype none

package sle_pkg;

    localparam int LAST_COLUMN_DEFAULT = 79;

    localparam logic [7:0] CAPACITY_RESET     = 8'd80;
    localparam logic [6:0] START_COLUMN_RESET = 7'd0;
    localparam logic [4:0] SCREEN_ROW_RESET   = 5'd0;
    localparam logic       MASK_ECHO_RESET    = 1'b0;

    localparam logic [7:0] SC_ENTER     = 8'h1C;
    localparam logic [7:0] SC_BACKSPACE = 8'h0E;

    localparam logic [7:0] ATTR_CURSOR = 8'h0A;
    localparam logic [7:0] ATTR_BLANK  = 8'h07;
    localparam logic [7:0] ATTR_ECHO   = 8'h0F;
    localparam logic [7:0] ATTR_NONE   = 8'h00;

    localparam logic [7:0] CH_CURSOR = 8'h5F;
    localparam logic [7:0] CH_BLANK  = 8'h20;
    localparam logic [7:0] CH_MASK   = 8'h2A;
    localparam logic [7:0] CH_TERM   = 8'h00;

    localparam logic TARGET_SCREEN = 1'b0;
    localparam logic TARGET_BUFFER = 1'b1;

    localparam int MAX_RESULTS = 3;

    typedef enum logic {
        OP_OPEN = 1'b0,
        OP_KEY  = 1'b1
    } opcode_t;

    typedef enum logic [1:0] {
        REG_CAPACITY     = 2'd0,
        REG_START_COLUMN = 2'd1,
        REG_SCREEN_ROW   = 2'd2,
        REG_MASK_ECHO    = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic       target;
        logic [7:0] ch;
        logic [7:0] position;
        logic [7:0] attribute;
        logic       line_done;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] char_index;
        logic [6:0] cursor_column;
        logic       line_active;
    } line_state_t;

    typedef struct packed {
        logic [7:0] line_capacity;
        logic [6:0] start_column;
        logic [4:0] screen_row;
        logic       mask_echo;
    } cfg_t;

    function automatic logic [7:0] key_map(input logic [6:0] code);
        logic [7:0] key;
        unique case (code)
            7'h01:   key = 8'h1B;
            7'h02:   key = "1";
            7'h03:   key = "2";
            7'h04:   key = "3";
            7'h05:   key = "4";
            7'h06:   key = "5";
            7'h07:   key = "6";
            7'h08:   key = "7";
            7'h09:   key = "8";
            7'h0A:   key = "9";
            7'h0B:   key = "0";
            7'h10:   key = "Q";
            7'h11:   key = "W";
            7'h12:   key = "E";
            7'h13:   key = "R";
            7'h14:   key = "T";
            7'h15:   key = "Y";
            7'h16:   key = "U";
            7'h17:   key = "I";
            7'h18:   key = "O";
            7'h19:   key = "P";
            7'h1E:   key = "A";
            7'h1F:   key = "S";
            7'h20:   key = "D";
            7'h21:   key = "F";
            7'h22:   key = "G";
            7'h23:   key = "H";
            7'h24:   key = "J";
            7'h25:   key = "K";
            7'h26:   key = "L";
            7'h2C:   key = "Z";
            7'h2D:   key = "X";
            7'h2E:   key = "C";
            7'h2F:   key = "V";
            7'h30:   key = "B";
            7'h31:   key = "N";
            7'h32:   key = "M";
            7'h39:   key = " ";
            default: key = 8'h00;
        endcase
        return key;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sle_step.sv
`default_nettype none

module sle_step #(
    parameter int LAST_COLUMN = sle_pkg::LAST_COLUMN_DEFAULT
) (
    input  var sle_pkg::opcode_t     opcode,
    input  var logic [7:0]           scancode,
    input  var sle_pkg::line_state_t cur,
    input  var sle_pkg::cfg_t        cfg,
    output sle_pkg::line_state_t     nxt,
    output sle_pkg::result_t         res [sle_pkg::MAX_RESULTS],
    output logic [1:0]               count
);

    localparam logic [7:0] LastCol = 8'(LAST_COLUMN);

    logic [7:0] key;
    logic       fits;
    logic [6:0] col_inc;
    logic [6:0] col_dec;

    assign key     = sle_pkg::key_map(scancode[6:0]);
    assign col_inc = cur.cursor_column + 7'd1;
    assign col_dec = cur.cursor_column - 7'd1;
    assign fits    = (key != 8'h00)
                  && (({1'b0, cur.char_index} + 9'd1) < {1'b0, cfg.line_capacity})
                  && ({1'b0, cur.cursor_column} < LastCol)
                  && (cur.cursor_column != 7'h7F);

    always_comb
    begin
        nxt   = cur;
        count = 2'd0;
        for (int i = 0; i < sle_pkg::MAX_RESULTS; i++)
        begin
            res[i] = '0;
        end

        if (opcode == sle_pkg::OP_OPEN)
        begin
            nxt.char_index    = 8'd0;
            nxt.cursor_column = cfg.start_column;
            nxt.line_active   = 1'b1;
            res[0] = '{sle_pkg::TARGET_SCREEN, sle_pkg::CH_CURSOR, {1'b0, cfg.start_column},
                       sle_pkg::ATTR_CURSOR, 1'b0, 1'b1};
            count  = 2'd1;
        end
        else if (cur.line_active && !scancode[7])
        begin
            priority if (scancode == sle_pkg::SC_ENTER)
            begin
                res[0] = '{sle_pkg::TARGET_SCREEN, sle_pkg::CH_BLANK,
                           {1'b0, cur.cursor_column}, sle_pkg::ATTR_BLANK, 1'b1, 1'b0};
                res[1] = '{sle_pkg::TARGET_BUFFER, sle_pkg::CH_TERM, cur.char_index,
                           sle_pkg::ATTR_NONE, 1'b1, 1'b1};
                count  = 2'd2;
                nxt.line_active = 1'b0;
            end
            else if (scancode == sle_pkg::SC_BACKSPACE)
            begin
                if (cur.char_index != 8'd0)
                begin
                    res[0] = '{sle_pkg::TARGET_SCREEN, sle_pkg::CH_BLANK,
                               {1'b0, cur.cursor_column}, sle_pkg::ATTR_BLANK, 1'b0, 1'b0};
                    res[1] = '{sle_pkg::TARGET_SCREEN, sle_pkg::CH_CURSOR,
                               {1'b0, col_dec}, sle_pkg::ATTR_CURSOR, 1'b0, 1'b1};
                    count  = 2'd2;
                    nxt.cursor_column = col_dec;
                    nxt.char_index    = cur.char_index - 8'd1;
                end
            end
            else
            begin
                if (fits)
                begin
                    res[0] = '{sle_pkg::TARGET_BUFFER, key, cur.char_index,
                               sle_pkg::ATTR_NONE, 1'b0, 1'b0};
                    res[1] = '{sle_pkg::TARGET_SCREEN, cfg.mask_echo ? sle_pkg::CH_MASK : key,
                               {1'b0, cur.cursor_column}, sle_pkg::ATTR_ECHO, 1'b0, 1'b0};
                    res[2] = '{sle_pkg::TARGET_SCREEN, sle_pkg::CH_CURSOR,
                               {1'b0, col_inc}, sle_pkg::ATTR_CURSOR, 1'b0, 1'b1};
                    count  = 2'd3;
                    nxt.cursor_column = col_inc;
                    nxt.char_index    = cur.char_index + 8'd1;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/sle_out.sv
`default_nettype none

module sle_out (
    input  var logic             clk,
    input  var logic             rst_n,
    input  var logic             load,
    input  var sle_pkg::result_t batch [sle_pkg::MAX_RESULTS],
    input  var logic [1:0]       count,
    output logic                 free,
    output logic                 m_tvalid,
    input  var logic             m_tready,
    output logic [31:0]          m_tdata,   // ch[7:0], position[15:8], attribute[23:16], line_done[24]
    output logic [0:0]           m_tuser,   // target[0]
    output logic                 m_tlast
);

    sle_pkg::result_t res_reg [sle_pkg::MAX_RESULTS];
    logic [1:0]       left_reg;
    logic [1:0]       left_next;
    logic [1:0]       idx_reg;
    logic [1:0]       idx_next;
    sle_pkg::result_t cur;
    logic             fire;

    assign m_tvalid = (left_reg != 2'd0);
    assign fire     = m_tvalid && m_tready;
    assign free     = (left_reg == 2'd0) || ((left_reg == 2'd1) && m_tready);

    always_comb
    begin
        unique case (idx_reg)
            2'd1:    cur = res_reg[1];
            2'd2:    cur = res_reg[2];
            default: cur = res_reg[0];
        endcase
    end

    assign m_tdata = {7'd0, cur.line_done, cur.attribute, cur.position, cur.ch};
    assign m_tuser = cur.target;
    assign m_tlast = cur.last;

    always_comb
    begin
        left_next = left_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            left_next = count;
            idx_next  = 2'd0;
        end
        else if (fire)
        begin
            left_next = left_reg - 2'd1;
            idx_next  = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg <= 2'd0;
            idx_reg  <= 2'd0;
        end
        else
        begin
            left_reg <= left_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= batch;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/scancode_line_editor.sv
// Scancode line editor: takes PC set 1 scancode bytes (tdata) with an opcode in tuser
// (0 opens a line, 1 delivers a byte) and edits one input line, giving screen cell writes
// and line buffer writes as results, at most three per request, the final one marked by
// tlast. Each request is held in an input register, worked out combinationally and loaded as
// a batch into the result registers; results leave one per cycle while m_tready is high. The
// next request can wait in the input register while the previous batch drains and is loaded
// as its last result leaves. The serializer, one result per cycle unless stalled, sets the rate.
// Registers (APB, byte address 4*i): line_capacity, start_column, screen_row, mask_echo.
// screen_row is stored and read back only.
`default_nettype none

module scancode_line_editor #(
    parameter int LAST_COLUMN = sle_pkg::LAST_COLUMN_DEFAULT
) (
    input  var logic        clk,
    input  var logic        rst_n,
    input  var logic        s_tvalid,
    output logic            s_tready,
    input  var logic [7:0]  s_tdata,   // scancode[7:0]
    input  var logic [0:0]  s_tuser,   // opcode[0]
    output logic            m_tvalid,
    input  var logic        m_tready,
    output logic [31:0]     m_tdata,   // ch[7:0], position[15:8], attribute[23:16], line_done[24]
    output logic [0:0]      m_tuser,   // target[0]
    output logic            m_tlast,
    input  var logic        psel,
    input  var logic        penable,
    input  var logic        pwrite,
    input  var logic [3:0]  paddr,
    input  var logic [31:0] pwdata,
    output logic [31:0]     prdata,
    output logic            pready
);

    sle_pkg::cfg_t        cfg_reg;
    sle_pkg::line_state_t state_reg;
    sle_pkg::line_state_t state_next;
    logic                 in_valid_reg;
    sle_pkg::opcode_t     in_opcode_reg;
    logic [7:0]           in_scancode_reg;
    logic                 in_take;
    logic                 in_accept;
    logic                 free;
    logic                 cfg_write;
    sle_pkg::cfg_reg_t    reg_sel;
    sle_pkg::result_t     batch [sle_pkg::MAX_RESULTS];
    logic [1:0]           count;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = sle_pkg::cfg_reg_t'(paddr[3:2]);

    always_comb
    begin
        unique case (reg_sel)
            sle_pkg::REG_CAPACITY:     prdata = {24'd0, cfg_reg.line_capacity};
            sle_pkg::REG_START_COLUMN: prdata = {25'd0, cfg_reg.start_column};
            sle_pkg::REG_SCREEN_ROW:   prdata = {27'd0, cfg_reg.screen_row};
            sle_pkg::REG_MASK_ECHO:    prdata = {31'd0, cfg_reg.mask_echo};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.line_capacity <= sle_pkg::CAPACITY_RESET;
            cfg_reg.start_column  <= sle_pkg::START_COLUMN_RESET;
            cfg_reg.screen_row    <= sle_pkg::SCREEN_ROW_RESET;
            cfg_reg.mask_echo     <= sle_pkg::MASK_ECHO_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_sel)
                sle_pkg::REG_CAPACITY:     cfg_reg.line_capacity <= pwdata[7:0];
                sle_pkg::REG_START_COLUMN: cfg_reg.start_column  <= pwdata[6:0];
                sle_pkg::REG_SCREEN_ROW:   cfg_reg.screen_row    <= pwdata[4:0];
                sle_pkg::REG_MASK_ECHO:    cfg_reg.mask_echo     <= pwdata[0];
                default:                   cfg_reg.mask_echo     <= cfg_reg.mask_echo;
            endcase
        end
    end

    // input register
    assign in_take   = in_valid_reg && free;
    assign s_tready  = !in_valid_reg || in_take;
    assign in_accept = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (in_take)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_opcode_reg   <= sle_pkg::opcode_t'(s_tuser[0]);
            in_scancode_reg <= s_tdata;
        end
    end

    // line state
    sle_step #(
        .LAST_COLUMN(LAST_COLUMN)
    ) u_step (
        .opcode   (in_opcode_reg),
        .scancode (in_scancode_reg),
        .cur      (state_reg),
        .cfg      (cfg_reg),
        .nxt      (state_next),
        .res      (batch),
        .count    (count)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_take)
        begin
            state_reg <= state_next;
        end
    end

    sle_out u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (in_take),
        .batch    (batch),
        .count    (count),
        .free     (free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

FILE: hw/rtl/sle_checker.sv
`default_nettype none

module sle_checker (
    input var logic        clk,
    input var logic        rst_n,
    input var logic        m_tvalid,
    input var logic        m_tready,
    input var logic [31:0] m_tdata,
    input var logic [0:0]  m_tuser,
    input var logic        m_tlast,
    input var logic        pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("stalled result changed");

    // buffer writes carry no attribute
    a_buf_attr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == sle_pkg::TARGET_BUFFER) |-> m_tdata[23:16] == 8'h00)
        else $error("buffer write with attribute");

    // screen writes use a known attribute
    a_scr_attr: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[0] == sle_pkg::TARGET_SCREEN) |->
            m_tdata[23:16] == sle_pkg::ATTR_CURSOR || m_tdata[23:16] == sle_pkg::ATTR_BLANK
            || m_tdata[23:16] == sle_pkg::ATTR_ECHO)
        else $error("screen write with bad attribute");

    // end of line: terminator closes the request
    a_done_term: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[24] && (m_tuser[0] == sle_pkg::TARGET_BUFFER) |->
            m_tlast && m_tdata[7:0] == sle_pkg::CH_TERM)
        else $error("line terminator misplaced");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind scancode_line_editor sle_checker u_sle_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .pready   (pready)
);

`default_nettype wire
